>>> rtl/lrc_pkg.sv
// Shared constants, register codes and the configuration struct of the line rasterizer.
package lrc_pkg;

	// Default coordinate width (two's complement)
	localparam int COORD_BITS_DEF = 12;

	// Fixed field widths
	localparam int CFG_BITS     = 11;
	localparam int ADDR_BITS    = 22;
	localparam int COLOR_BITS   = 8;
	localparam int CFG_IDX_BITS = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_PITCH     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROTATE_DISPLAY = 2'd3;

	// Register reset values
	localparam logic [CFG_BITS-1:0] RST_SCREEN_WIDTH  = 11'd360;
	localparam logic [CFG_BITS-1:0] RST_SCREEN_HEIGHT = 11'd240;
	localparam logic [CFG_BITS-1:0] RST_LINE_PITCH    = 11'd360;

	// Command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Current register set
	typedef struct packed {
		logic [CFG_BITS-1:0] screen_width;
		logic [CFG_BITS-1:0] screen_height;
		logic [CFG_BITS-1:0] line_pitch;
		logic                rotate_display;
	} cfg_t;

endpackage

>>> rtl/line_rasterizer_with_clipping.sv
// Top level of the clipping Bresenham line rasterizer.
// A start item (cmd 0) loads the endpoints and color and yields no result; each step item
// (cmd 1) while a line is active yields one pixel, from the endpoint with the lower major-axis
// coordinate to the other, with last set on the final one; a step with no active line yields
// nothing. One item is taken per clock cycle, starts and steps alike, while out_ready does not
// hold the pipeline back, as the Bresenham stepper computes its next error term combinationally.
// A pixel passes the step register, the multiply stage and the output register, in that order,
// before it is on the output. Register writes are taken at any time, one per cycle, but
// should only be made while no pixel is in flight.
module line_rasterizer_with_clipping import lrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic        [CFG_IDX_BITS-1:0] cfg_index,
	input  logic        [CFG_BITS-1:0]    cfg_data,
	// Command items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	input  logic        [COLOR_BITS-1:0]  pen_color,
	// Pixel items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  pixel_x,
	output logic signed [COORD_BITS-1:0]  pixel_y,
	output logic                          visible,
	output logic        [ADDR_BITS-1:0]   pixel_addr,
	output logic        [COLOR_BITS-1:0]  pixel_color,
	output logic                          last
);

	// Register set
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width   <= RST_SCREEN_WIDTH;
			cfg_q.screen_height  <= RST_SCREEN_HEIGHT;
			cfg_q.line_pitch     <= RST_LINE_PITCH;
			cfg_q.rotate_display <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:   cfg_q.screen_width   <= cfg_data;
				CFG_SCREEN_HEIGHT:  cfg_q.screen_height  <= cfg_data;
				CFG_LINE_PITCH:     cfg_q.line_pitch     <= cfg_data;
				CFG_ROTATE_DISPLAY: cfg_q.rotate_display <= cfg_data[0];
			endcase
		end
	end

	// Mirror base (height-1)*pitch + width-1, refreshed every cycle
	logic [ADDR_BITS-1:0] base_q;

	always_ff @(posedge clk) begin
		base_q <= ADDR_BITS'(cfg_q.screen_height) * ADDR_BITS'(cfg_q.line_pitch)
		          - ADDR_BITS'(cfg_q.line_pitch) + ADDR_BITS'(cfg_q.screen_width)
		          - ADDR_BITS'(1);
	end

	// Input handshake and stepper
	logic                         in_fire, s1_free, map_ready, busy, cur_last;
	logic signed [COORD_BITS-1:0] cur_x, cur_y;
	logic        [COLOR_BITS-1:0] cur_color;

	assign in_ready = s1_free;
	assign in_fire  = in_valid && in_ready;

	lrc_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire),
		.cmd       (cmd),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.pen_color (pen_color),
		.busy      (busy),
		.cur_x     (cur_x),
		.cur_y     (cur_y),
		.cur_color (cur_color),
		.cur_last  (cur_last)
	);

	// Step register: pixel taken from the stepper state
	logic                         valid_s1, last_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1;
	logic        [COLOR_BITS-1:0] color_s1;
	logic                         emit;

	assign s1_free = !valid_s1 || map_ready;
	assign emit    = in_fire && (cmd == CMD_STEP) && busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			px_s1    <= cur_x;
			py_s1    <= cur_y;
			color_s1 <= cur_color;
			last_s1  <= cur_last;
		end
	end

	lrc_pixel_map #(.COORD_BITS(COORD_BITS)) u_pixel_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.base        (base_q),
		.pix_valid   (valid_s1),
		.pix_ready   (map_ready),
		.pix_x       (px_s1),
		.pix_y       (py_s1),
		.pix_color   (color_s1),
		.pix_last    (last_s1),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.visible     (visible),
		.pixel_addr  (pixel_addr),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule

>>> rtl/lrc_stepper.sv
// Bresenham line state: setup on a start item, one pixel per step item while a line is active.
module lrc_stepper import lrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         cmd,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic        [COLOR_BITS-1:0] pen_color,
	output logic                         busy,
	output logic signed [COORD_BITS-1:0] cur_x,
	output logic signed [COORD_BITS-1:0] cur_y,
	output logic        [COLOR_BITS-1:0] cur_color,
	output logic                         cur_last
);

	localparam int C = COORD_BITS;

	logic signed [C-1:0] major_pos_q, minor_pos_q, major_end_q;
	logic signed [C+1:0] error_acc_q;
	logic        [C-1:0] major_delta_q, minor_delta_q;
	logic                minor_step_down_q, axes_swapped_q, busy_q;
	logic [COLOR_BITS-1:0] held_color_q;

	// Setup: deltas, steepness, endpoint order
	logic signed [C:0]   dx, dy, dx_neg, dy_neg;
	logic        [C-1:0] adx, ady;
	logic                steep, flip;
	logic signed [C-1:0] a_maj, a_min, b_maj, b_min, first_maj, first_min, last_maj, last_min;

	always_comb begin
		dx     = {end_x[C-1], end_x} - {start_x[C-1], start_x};
		dy     = {end_y[C-1], end_y} - {start_y[C-1], start_y};
		dx_neg = -dx;
		dy_neg = -dy;
		adx    = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
		ady    = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
		steep  = ady > adx;
		a_maj  = steep ? start_y : start_x;
		a_min  = steep ? start_x : start_y;
		b_maj  = steep ? end_y : end_x;
		b_min  = steep ? end_x : end_y;
		flip   = a_maj > b_maj;
		first_maj = flip ? b_maj : a_maj;
		first_min = flip ? b_min : a_min;
		last_maj  = flip ? a_maj : b_maj;
		last_min  = flip ? a_min : b_min;
	end

	// Step: error update and minor move
	logic signed [C+1:0] e_sum, e_next;
	logic signed [C+2:0] e_twice;
	logic                minor_move, is_last;

	always_comb begin
		e_sum      = error_acc_q + $signed({2'b00, minor_delta_q});
		e_twice    = {e_sum, 1'b0};
		minor_move = e_twice >= $signed({3'b000, major_delta_q});
		e_next     = minor_move ? e_sum - $signed({2'b00, major_delta_q}) : e_sum;
		is_last    = major_pos_q >= major_end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q       <= '0;
			minor_pos_q       <= '0;
			major_end_q       <= '0;
			error_acc_q       <= '0;
			major_delta_q     <= '0;
			minor_delta_q     <= '0;
			minor_step_down_q <= 1'b0;
			axes_swapped_q    <= 1'b0;
			held_color_q      <= '0;
			busy_q            <= 1'b0;
		end else if (fire) begin
			if (cmd == CMD_START) begin
				major_pos_q       <= first_maj;
				minor_pos_q       <= first_min;
				major_end_q       <= last_maj;
				error_acc_q       <= '0;
				major_delta_q     <= steep ? ady : adx;
				minor_delta_q     <= steep ? adx : ady;
				minor_step_down_q <= !(first_min < last_min);
				axes_swapped_q    <= steep;
				held_color_q      <= pen_color;
				busy_q            <= 1'b1;
			end else if (busy_q) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					major_pos_q <= major_pos_q + C'(1);
					error_acc_q <= e_next;
					if (minor_move) begin
						minor_pos_q <= minor_step_down_q ? minor_pos_q - C'(1)
						                                 : minor_pos_q + C'(1);
					end
				end
			end
		end
	end

	assign busy      = busy_q;
	assign cur_x     = axes_swapped_q ? minor_pos_q : major_pos_q;
	assign cur_y     = axes_swapped_q ? major_pos_q : minor_pos_q;
	assign cur_color = held_color_q;
	assign cur_last  = is_last;

endmodule

>>> rtl/lrc_pixel_map.sv
// Clipping and frame buffer address: a multiply stage and the output register.
module lrc_pixel_map import lrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic        [ADDR_BITS-1:0]  base,
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic signed [COORD_BITS-1:0] pix_x,
	input  logic signed [COORD_BITS-1:0] pix_y,
	input  logic        [COLOR_BITS-1:0] pix_color,
	input  logic                         pix_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         visible,
	output logic        [ADDR_BITS-1:0]  pixel_addr,
	output logic        [COLOR_BITS-1:0] pixel_color,
	output logic                         last
);

	localparam int C  = COORD_BITS;
	localparam int CW = (C - 1 > CFG_BITS) ? C - 1 : CFG_BITS;

	// Handshake between stages
	logic out_free, s2_free;
	logic valid_s2, out_valid_q;

	assign out_free  = !out_valid_q || out_ready;
	assign s2_free   = !valid_s2 || out_free;
	assign pix_ready = s2_free;

	// Clip test and row offset product
	logic [CW-1:0] px_u, py_u;
	logic          vis;

	always_comb begin
		px_u = CW'(pix_x[C-2:0]);
		py_u = CW'(pix_y[C-2:0]);
		vis  = !pix_x[C-1] && !pix_y[C-1] &&
		       (px_u < CW'(cfg.screen_width)) && (py_u < CW'(cfg.screen_height)) &&
		       !((pix_x == '0) && (pix_y == '0));
	end

	logic                  vis_s2, last_s2;
	logic [ADDR_BITS-1:0]  prod_s2;
	logic [CFG_BITS-1:0]   pxl_s2;
	logic signed [C-1:0]   px_s2, py_s2;
	logic [COLOR_BITS-1:0] color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && pix_valid) begin
			vis_s2   <= vis;
			prod_s2  <= ADDR_BITS'(py_u[CFG_BITS-1:0]) * ADDR_BITS'(cfg.line_pitch);
			pxl_s2   <= px_u[CFG_BITS-1:0];
			px_s2    <= pix_x;
			py_s2    <= pix_y;
			color_s2 <= pix_color;
			last_s2  <= pix_last;
		end
	end

	// Offset, optional mirror, zero for clipped pixels
	logic [ADDR_BITS-1:0] offset, addr;

	always_comb begin
		offset = prod_s2 + ADDR_BITS'(pxl_s2);
		if (!vis_s2) begin
			addr = '0;
		end else if (cfg.rotate_display) begin
			addr = base - offset;
		end else begin
			addr = offset;
		end
	end

	logic signed [C-1:0]   px_q, py_q;
	logic                  vis_q, last_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [COLOR_BITS-1:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			px_q    <= px_s2;
			py_q    <= py_s2;
			vis_q   <= vis_s2;
			addr_q  <= addr;
			color_q <= color_s2;
			last_q  <= last_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign visible     = vis_q;
	assign pixel_addr  = addr_q;
	assign pixel_color = color_q;
	assign last        = last_q;

endmodule

>>> rtl/lrc_checker.sv
// Port-level checks of the line rasterizer, bound to the top level.
module lrc_checker import lrc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [COORD_BITS-1:0] pixel_x,
	input logic signed [COORD_BITS-1:0] pixel_y,
	input logic                         visible,
	input logic        [ADDR_BITS-1:0]  pixel_addr,
	input logic        [COLOR_BITS-1:0] pixel_color,
	input logic                         last
);

	// A stalled pixel item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
		$stable(pixel_addr) && $stable(pixel_color) && $stable(last))
		else $error("pixel item changed while stalled");

	// Clipped pixels carry a zero address
	a_clip_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> pixel_addr == '0)
		else $error("clipped pixel with nonzero address");

	// The guard pixel is never marked visible
	a_guard: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && visible |-> (pixel_x != '0) || (pixel_y != '0))
		else $error("guard pixel marked visible");

	// Visible pixels have no negative coordinate
	a_vis_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && visible |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
		else $error("visible pixel with negative coordinate");

endmodule

bind line_rasterizer_with_clipping lrc_checker #(.COORD_BITS(COORD_BITS)) u_lrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.visible     (visible),
	.pixel_addr  (pixel_addr),
	.pixel_color (pixel_color),
	.last        (last)
);
